// ===== rtl/hbridge_motor_channel_with_lowpass_macros.svh =====
// Assertion macros used by the checker file.
`ifndef HBRIDGE_MOTOR_CHANNEL_WITH_LOWPASS_MACROS_SVH
`define HBRIDGE_MOTOR_CHANNEL_WITH_LOWPASS_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HMC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hmc: same-cycle property failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HMC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hmc: next-cycle property failed");

`endif

// ===== rtl/hmc_pkg.sv =====
package hmc_pkg;

	localparam int DUTY_W   = 8;
	localparam int CODE_W   = 8;
	localparam int SCALE_W  = 12;
	localparam int ALPHA_W  = 16;
	localparam int LEVEL_W  = 28;
	localparam int CMP_W    = 12;
	localparam int CNT_W    = 16;
	localparam int PROD_W   = LEVEL_W + ALPHA_W + 1;
	localparam int ITER_W   = 5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// multiply lengths in bits of the serial operand
	localparam logic [ITER_W-1:0] TARGET_ITERS = 5'd8;
	localparam logic [ITER_W-1:0] STEP_ITERS   = 5'd16;

	localparam logic [CMP_W-1:0] CMP_MAX      = 12'hFFF;
	localparam logic [CNT_W-1:0] CNT_MAX      = 16'hFFFF;
	localparam logic [CNT_W-1:0] RELOAD_COUNT = 16'd52;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FORWARD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_CMP = 3'd7;

	// register reset values
	localparam logic [ALPHA_W-1:0] RST_ALPHA    = 16'd8913;
	localparam logic [SCALE_W-1:0] RST_SCALE    = 12'd2409;
	localparam logic [CODE_W-1:0]  RST_STOP     = 8'd0;
	localparam logic [CODE_W-1:0]  RST_FORWARD  = 8'd1;
	localparam logic [CODE_W-1:0]  RST_REVERSE  = 8'd2;
	localparam logic [CNT_W-1:0]   RST_LIMIT    = 16'd50;
	localparam logic [CMP_W-1:0]   RST_STOP_CMP = 12'd2400;

	// pin levels: bit 0 pin_a, bit 1 pin_b
	localparam logic [1:0] PINS_STOP = 2'b11;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} filt_stat_t;

endpackage

// ===== rtl/hbridge_motor_channel_with_lowpass.sv =====
// A tick sets a result pending when accepted; a frame runs duty*scale and then alpha*error
//   on the shared bit-serial multiplier before its result is pending. A pending result moves
//   into the output register; the input is stalled until then, so one transaction is in flight.
// Reset (arst_n low, asynchronous): registers to their defaults, filter level 0, watchdog 0,
//   connected, held pin levels both high, held compare 2400, no result pending.
module hbridge_motor_channel_with_lowpass (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [hmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hmc_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              operation,
	input  logic [hmc_pkg::CODE_W-1:0]        direction_byte,
	input  logic [hmc_pkg::DUTY_W-1:0]        duty_byte,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              pin_a,
	output logic                              pin_b,
	output logic [hmc_pkg::CMP_W-1:0]         compare_value,
	output logic                              link_lost
);

	// configuration registers
	logic [hmc_pkg::ALPHA_W-1:0]  alpha_q;
	logic [hmc_pkg::SCALE_W-1:0]  scale_q;
	logic                         invert_q;
	logic [hmc_pkg::CODE_W-1:0]   stop_code_q;
	logic [hmc_pkg::CODE_W-1:0]   fwd_code_q;
	logic [hmc_pkg::CODE_W-1:0]   rev_code_q;
	logic [hmc_pkg::CNT_W-1:0]    limit_q;
	logic [hmc_pkg::CMP_W-1:0]    stop_cmp_q;

	// channel state
	logic [hmc_pkg::CNT_W-1:0]    link_cnt_q;
	logic                         disc_q;
	logic [1:0]                   pins_q;
	logic [hmc_pkg::CMP_W-1:0]    last_cmp_q;
	logic [hmc_pkg::CODE_W-1:0]   dir_q;
	logic                         res_pend_q;

	// output register
	logic                         out_valid_q;
	logic [1:0]                   out_pins_q;
	logic [hmc_pkg::CMP_W-1:0]    out_cmp_q;
	logic                         out_lost_q;

	logic                         in_acc;
	logic                         out_free;
	logic                         frame_start;
	hmc_pkg::filt_stat_t          filt_stat;
	logic [hmc_pkg::CMP_W-1:0]    filt_cmp;

	logic [hmc_pkg::CNT_W-1:0]    tick_cnt;
	logic                         tick_disc;
	logic [1:0]                   frame_pins;
	logic [hmc_pkg::CMP_W-1:0]    frame_cmp;

	// Hold the input side while a frame filters or a result waits for the output register.
	assign in_stall    = filt_stat.busy | res_pend_q;
	assign in_acc      = in_valid & ~in_stall;
	assign frame_start = in_acc & ~operation;
	assign out_free    = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= hmc_pkg::RST_ALPHA;
			scale_q     <= hmc_pkg::RST_SCALE;
			invert_q    <= 1'b0;
			stop_code_q <= hmc_pkg::RST_STOP;
			fwd_code_q  <= hmc_pkg::RST_FORWARD;
			rev_code_q  <= hmc_pkg::RST_REVERSE;
			limit_q     <= hmc_pkg::RST_LIMIT;
			stop_cmp_q  <= hmc_pkg::RST_STOP_CMP;
		end else if (cfg_we) begin
			case (cfg_index)
				hmc_pkg::REG_ALPHA:    alpha_q     <= cfg_data;
				hmc_pkg::REG_SCALE:    scale_q     <= cfg_data[hmc_pkg::SCALE_W-1:0];
				hmc_pkg::REG_INVERT:   invert_q    <= cfg_data[0];
				hmc_pkg::REG_STOP:     stop_code_q <= cfg_data[hmc_pkg::CODE_W-1:0];
				hmc_pkg::REG_FORWARD:  fwd_code_q  <= cfg_data[hmc_pkg::CODE_W-1:0];
				hmc_pkg::REG_REVERSE:  rev_code_q  <= cfg_data[hmc_pkg::CODE_W-1:0];
				hmc_pkg::REG_LIMIT:    limit_q     <= cfg_data;
				hmc_pkg::REG_STOP_CMP: stop_cmp_q  <= cfg_data[hmc_pkg::CMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	hmc_filter u_filter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (frame_start),
		.duty   (duty_byte),
		.scale  (scale_q),
		.alpha  (alpha_q),
		.stat   (filt_stat),
		.cmp    (filt_cmp)
	);

	// Watchdog: past the limit, disconnect and reload; then advance, saturating.
	always_comb begin
		tick_cnt  = link_cnt_q;
		tick_disc = disc_q;
		if (link_cnt_q > limit_q) begin
			tick_disc = 1'b1;
			tick_cnt  = hmc_pkg::RELOAD_COUNT;
		end
		if (tick_cnt != hmc_pkg::CNT_MAX) begin
			tick_cnt = tick_cnt + 1'b1;
		end
	end

	// Direction decode with stop taking priority, then forward, then reverse.
	// An unknown code keeps the pins but still takes the filtered compare.
	always_comb begin
		frame_pins = pins_q;
		frame_cmp  = filt_cmp;
		if (dir_q == stop_code_q) begin
			frame_pins = hmc_pkg::PINS_STOP;
			frame_cmp  = stop_cmp_q;
		end else if (dir_q == fwd_code_q) begin
			frame_pins = {invert_q, ~invert_q};
		end else if (dir_q == rev_code_q) begin
			frame_pins = {~invert_q, invert_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_cnt_q <= '0;
			disc_q     <= 1'b0;
			pins_q     <= hmc_pkg::PINS_STOP;
			last_cmp_q <= hmc_pkg::RST_STOP_CMP;
			res_pend_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (operation) begin
					link_cnt_q <= tick_cnt;
					disc_q     <= tick_disc;
					if (tick_disc) begin
						pins_q     <= hmc_pkg::PINS_STOP;
						last_cmp_q <= stop_cmp_q;
					end
					res_pend_q <= 1'b1;
				end else begin
					// a frame reconnects the channel before it is filtered
					link_cnt_q <= '0;
					disc_q     <= 1'b0;
				end
			end else if (filt_stat.done) begin
				pins_q     <= frame_pins;
				last_cmp_q <= frame_cmp;
				res_pend_q <= 1'b1;
			end else if (res_pend_q && out_free) begin
				res_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_start) begin
			dir_q <= direction_byte;
		end
	end

	// Output register: load the channel state when a result is pending and the slot frees.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_pend_q && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_pend_q && out_free) begin
			out_pins_q <= pins_q;
			out_cmp_q  <= last_cmp_q;
			out_lost_q <= disc_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign pin_a         = out_pins_q[0];
	assign pin_b         = out_pins_q[1];
	assign compare_value = out_cmp_q;
	assign link_lost     = out_lost_q;

endmodule

// ===== rtl/hmc_serial_mul.sv =====
// Shift-add multiplier, one bit of b per cycle, LSB first.
module hmc_serial_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [hmc_pkg::LEVEL_W-1:0]     a,
	input  logic [hmc_pkg::ALPHA_W-1:0]     b,
	input  logic [hmc_pkg::ITER_W-1:0]      iters,
	output hmc_pkg::mul_stat_t              stat,
	output logic [hmc_pkg::PROD_W-1:0]      p
);

	localparam int HI_W = hmc_pkg::PROD_W - hmc_pkg::ALPHA_W;

	logic [hmc_pkg::PROD_W-1:0] p_q;
	logic [hmc_pkg::ITER_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [HI_W-1:0]            sum;

	assign sum = p_q[hmc_pkg::PROD_W-1:hmc_pkg::ALPHA_W]
		+ {1'b0, a & {hmc_pkg::LEVEL_W{p_q[0]}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == hmc_pkg::ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the sum with its carry right by one, so the top bit refills with zero
	always_ff @(posedge clk) begin
		if (start) begin
			p_q <= {{HI_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {1'b0, sum, p_q[hmc_pkg::ALPHA_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign p         = p_q;

endmodule

// ===== rtl/hmc_filter.sv =====
// Duty scaling and first-order low-pass, both products on one serial multiplier.
module hmc_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [hmc_pkg::DUTY_W-1:0]      duty,
	input  logic [hmc_pkg::SCALE_W-1:0]     scale,
	input  logic [hmc_pkg::ALPHA_W-1:0]     alpha,
	output hmc_pkg::filt_stat_t             stat,
	output logic [hmc_pkg::CMP_W-1:0]       cmp
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_MUL1 = 3'd1;
	localparam logic [2:0] F_MUL2 = 3'd2;
	localparam logic [2:0] F_CMP  = 3'd3;

	logic [2:0]                     state_q;
	logic [hmc_pkg::LEVEL_W-1:0]    level_q;
	logic                           rise_q;
	logic [hmc_pkg::LEVEL_W-1:0]    diff_q;

	hmc_pkg::mul_stat_t             mul_stat;
	logic [hmc_pkg::PROD_W-1:0]     mul_p;
	logic                           mul_start;
	logic [hmc_pkg::LEVEL_W-1:0]    mul_a;
	logic [hmc_pkg::ALPHA_W-1:0]    mul_b;
	logic [hmc_pkg::ITER_W-1:0]     mul_iters;

	logic [hmc_pkg::LEVEL_W-1:0]    target;
	logic                           rise;
	logic [hmc_pkg::LEVEL_W-1:0]    diff;
	logic [hmc_pkg::LEVEL_W-1:0]    step_trunc;
	logic [hmc_pkg::LEVEL_W-1:0]    step;
	logic [hmc_pkg::CMP_W:0]        up;

	// target is duty*scale shifted left 8; the low 8 bits of the product word are zero
	assign target = mul_p[hmc_pkg::LEVEL_W-1:0];
	assign rise   = target >= level_q;
	assign diff   = rise ? (target - level_q) : (level_q - target);

	assign step_trunc = mul_p[hmc_pkg::ALPHA_W +: hmc_pkg::LEVEL_W];
	assign step = rise_q ? step_trunc
		: step_trunc + hmc_pkg::LEVEL_W'(|mul_p[hmc_pkg::ALPHA_W-1:0]);

	assign up = {1'b0, level_q[hmc_pkg::LEVEL_W-1:hmc_pkg::ALPHA_W]}
		+ (hmc_pkg::CMP_W+1)'(|level_q[hmc_pkg::ALPHA_W-1:0]);

	// the multiplicand must hold for the whole multiply: scale for the first, the held error
	// for the second
	always_comb begin
		mul_start = 1'b0;
		mul_a     = diff_q;
		mul_b     = alpha;
		mul_iters = hmc_pkg::STEP_ITERS;
		case (state_q)
			F_IDLE: begin
				mul_start = start;
				mul_a     = hmc_pkg::LEVEL_W'(scale);
				mul_b     = hmc_pkg::ALPHA_W'(duty);
				mul_iters = hmc_pkg::TARGET_ITERS;
			end
			F_MUL1: begin
				mul_start = mul_stat.done;
				mul_a     = hmc_pkg::LEVEL_W'(scale);
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	hmc_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.iters  (mul_iters),
		.stat   (mul_stat),
		.p      (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			level_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q <= F_MUL1;
					end
				end
				F_MUL1: begin
					if (mul_stat.done) begin
						state_q <= F_MUL2;
					end
				end
				F_MUL2: begin
					if (mul_stat.done) begin
						level_q <= rise_q ? (level_q + step) : (level_q - step);
						state_q <= F_CMP;
					end
				end
				F_CMP: begin
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_MUL1 && mul_stat.done) begin
			rise_q <= rise;
			diff_q <= diff;
		end
	end

	assign stat.busy = (state_q != F_IDLE);
	assign stat.done = (state_q == F_CMP);
	assign cmp = up[hmc_pkg::CMP_W] ? hmc_pkg::CMP_MAX : up[hmc_pkg::CMP_W-1:0];

endmodule

// ===== rtl/hmc_checker.sv =====
`include "hbridge_motor_channel_with_lowpass_macros.svh"

module hmc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic operation,
	input logic out_valid,
	input logic out_stall,
	input logic pin_a,
	input logic pin_b,
	input logic link_lost
);

	// a disconnected result always drives both bridge pins high
	`HMC_ASSERT_NOW(a_lost_pins_high, out_valid && link_lost, pin_a && pin_b)
	// an accepted tick blocks the next transaction while its result is pending
	`HMC_ASSERT_NEXT(a_tick_holds_input, in_valid && !in_stall && operation, in_stall)
	// an accepted frame blocks the input while it is filtered
	`HMC_ASSERT_NEXT(a_frame_holds_input, in_valid && !in_stall && !operation, in_stall)
	// a stalled result stays offered
	`HMC_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)

endmodule

bind hbridge_motor_channel_with_lowpass hmc_checker u_hmc_checker (.*);
